>>> design/vbe_pkg.sv
// Shared types, constants and the microcode table of the varint byte encoder.
package vbe_pkg;

  // Field widths
  localparam int unsigned ValueW = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StepW  = 2;

  typedef logic [StepW-1:0] step_t;

  // Program addresses
  localparam step_t STEP_IDLE   = 2'd0;
  localparam step_t STEP_GRP7   = 2'd1;
  localparam step_t STEP_FIRST6 = 2'd2;

  // Input command codes (carried on tuser)
  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

  // Micro-operations
  typedef enum logic [1:0] {
    OP_LOAD,    // wait for an input transfer, load the datapath
    OP_EMIT7,   // emit one 7-bit group, shift right by 7
    OP_EMIT6S   // emit sign plus low 6 bits, shift right by 6
  } op_e;

  // One control word: operation and the two jump targets
  typedef struct packed {
    op_e   op;
    step_t jmp_t;   // taken when the step's condition is true
    step_t jmp_f;   // taken otherwise
  } uword_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic emit7;
    logic emit6s;
  } ctl_t;

  // Conditions from the datapath to the sequencer
  typedef struct packed {
    logic more6;      // magnitude has bits above bit 5
    logic more7;      // value has bits above bit 6
    logic slot_free;  // output register can take a byte this cycle
  } stat_t;

  // Microcode ROM.
  // Idle: load, then branch on command. Group step loops while bits remain.
  function automatic uword_t ucode(step_t addr);
    uword_t w;
    case (addr)
      STEP_IDLE:   w = '{op: OP_LOAD,   jmp_t: STEP_FIRST6, jmp_f: STEP_GRP7};
      STEP_GRP7:   w = '{op: OP_EMIT7,  jmp_t: STEP_GRP7,   jmp_f: STEP_IDLE};
      STEP_FIRST6: w = '{op: OP_EMIT6S, jmp_t: STEP_GRP7,   jmp_f: STEP_IDLE};
      default:     w = '{op: OP_LOAD,   jmp_t: STEP_IDLE,   jmp_f: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> design/vbe_sequencer.sv
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
module vbe_sequencer import vbe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_cmd_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  step_t  step_q, step_d;
  uword_t uw;

  // Decode the current control word and pick the next step
  always_comb begin
    uw         = ucode(step_q);
    ctl_o      = '0;
    in_ready_o = 1'b0;
    step_d     = step_q;
    case (uw.op)
      OP_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          step_d     = (in_cmd_i == CMD_SIGNED) ? uw.jmp_t : uw.jmp_f;
        end
      end
      OP_EMIT7: begin
        if (stat_i.slot_free) begin
          ctl_o.emit7 = 1'b1;
          step_d      = stat_i.more7 ? uw.jmp_t : uw.jmp_f;
        end
      end
      OP_EMIT6S: begin
        if (stat_i.slot_free) begin
          ctl_o.emit6s = 1'b1;
          step_d       = stat_i.more6 ? uw.jmp_t : uw.jmp_f;
        end
      end
      default: begin
        step_d = STEP_IDLE;
      end
    endcase
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> design/vbe_datapath.sv
// Datapath: magnitude shift register, sign flag and the output byte register.
module vbe_datapath import vbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  output stat_t             stat_o,
  input  logic [ValueW-1:0] in_value_i,
  input  logic              in_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              out_last_o
);

  logic [ValueW-1:0] val_q, val_d;
  logic              sign_q, sign_d;
  logic              ovalid_q, ovalid_d;
  logic [ByteW-1:0]  obyte_q, obyte_d;
  logic              olast_q, olast_d;
  logic              neg;

  assign neg = (in_cmd_i == CMD_SIGNED) && in_value_i[ValueW-1];

  assign stat_o.more6     = |val_q[ValueW-1:6];
  assign stat_o.more7     = |val_q[ValueW-1:7];
  assign stat_o.slot_free = !ovalid_q || out_ready_i;

  // Load, shift and fill the output register
  always_comb begin
    val_d    = val_q;
    sign_d   = sign_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q && !out_ready_i;
    if (ctl_i.load) begin
      sign_d = neg;
      val_d  = neg ? (~in_value_i + ValueW'(1)) : in_value_i;
    end
    if (ctl_i.emit7) begin
      obyte_d  = {stat_o.more7, val_q[6:0]};
      olast_d  = !stat_o.more7;
      ovalid_d = 1'b1;
      val_d    = val_q >> 7;
    end
    if (ctl_i.emit6s) begin
      obyte_d  = {stat_o.more6, sign_q, val_q[5:0]};
      olast_d  = !stat_o.more6;
      ovalid_d = 1'b1;
      val_d    = val_q >> 6;
    end
  end

  // Control flag of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    sign_q  <= sign_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

>>> design/varint_byte_encoder.sv
// Top level of the varint byte encoder.
// Takes one 64-bit value per input transfer and emits its varint encoding one
// byte per output transfer, least significant group first, with tlast on the
// final byte. tuser = 0 gives plain unsigned 7-bit groups; tuser = 1 reads the
// value as two's complement and gives sign-magnitude form (sign in bit 6 of
// the first byte). A value is loaded and then gives 1 to 10 bytes, which the
// output side can hold back; the pace is set by the microcode sequencer,
// which emits one byte per step into a single output register and loads the
// next value only after the last byte of the current one has been placed
// there.
module varint_byte_encoder import vbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [ValueW-1:0] s_axis_tdata_i,   // [63:0] value_bits
  input  logic              s_axis_tuser_i,   // [0] command
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [ByteW-1:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic              m_axis_tlast_o
);

  ctl_t  ctl;
  stat_t stat;

  // Program control
  vbe_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // Shift register and output byte
  vbe_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .in_value_i  (s_axis_tdata_i),
    .in_cmd_i    (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
